[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default form: clk_i and rst_ni of the enclosing module
`define ASSERT_STD(label, prop, msg) \
  `ASSERT_CLKRST(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/trb_pkg.sv]
`default_nettype none

package trb_pkg;

  localparam int TIME_BITS = 63;
  localparam int FILL_W    = 6;
  localparam logic [FILL_W-1:0] FILL_RESET = 6'd20;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_MERGED   = 3'd1,
    ST_LATE     = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_RELEASED = 3'd4
  } status_e;

  typedef struct packed {
    time_t dev_time;
    logic  device_known;
    time_t request_time;
    logic  request_known;
    time_t receive_time;
    logic  receive_known;
  } in_item_t;

  typedef struct packed {
    status_e status;
    time_t   out_dev_time;
    time_t   out_request_time;
    logic    out_request_known;
    time_t   out_receive_time;
    logic    out_receive_known;
  } out_item_t;

  // one buffer entry as kept in the memory
  typedef struct packed {
    time_t dev_time;
    time_t request_time;
    time_t receive_time;
    logic  request_known;
    logic  receive_known;
  } entry_t;

endpackage

`default_nettype wire

[rtl/trb_mem.sv]
`default_nettype none

module trb_mem #(
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire trb_pkg::entry_t          wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output trb_pkg::entry_t               rdata_o
);

  trb_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/trb_merge.sv]
`default_nettype none

module trb_merge (
  input  wire trb_pkg::entry_t stored_i,
  input  wire trb_pkg::entry_t incoming_i,
  output trb_pkg::entry_t      merged_o
);

  always_comb begin
    merged_o = stored_i;
    // latest request time, unknown stored time is replaced outright
    if (!stored_i.request_known) begin
      merged_o.request_time  = incoming_i.request_time;
      merged_o.request_known = incoming_i.request_known;
    end else if (incoming_i.request_known &&
                 (incoming_i.request_time > stored_i.request_time)) begin
      merged_o.request_time = incoming_i.request_time;
    end
    // earliest receive time
    if (!stored_i.receive_known) begin
      merged_o.receive_time  = incoming_i.receive_time;
      merged_o.receive_known = incoming_i.receive_known;
    end else if (incoming_i.receive_known &&
                 (incoming_i.receive_time < stored_i.receive_time)) begin
      merged_o.receive_time = incoming_i.receive_time;
    end
  end

endmodule

`default_nettype wire

[rtl/timestamp_reorder_buffer.sv]
// dropped or late event: the result strobe comes out of the check state that follows the transfer
// otherwise the strobe comes after the entry scan, out of the merge or decide state
// next transfer at the edge ending the strobe; no new event is taken while busy
// result: one strobe cycle per event on result_valid_o, the receiver cannot stall
// reset: entry count, release mark and fill limit (20) clear at once, no memory clearing pass
`default_nettype none

module timestamp_reorder_buffer #(
  parameter int DEPTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // event command
  input  wire logic                            start,
  output logic                                 busy,
  input  wire trb_pkg::in_item_t               in_i,
  // result strobe
  output logic                                 result_valid_o,
  output trb_pkg::out_item_t                   result_o,
  // fill limit register write
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [trb_pkg::FILL_W-1:0]      cfg_data_i
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // width wide enough to compare the count against the fill limit
  localparam int LW = (CW > trb_pkg::FILL_W) ? CW : trb_pkg::FILL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_MERGE
  } state_e;

  state_e                      state_q;
  trb_pkg::in_item_t           item_q;      // accepted event, unknown local times zeroed
  trb_pkg::in_item_t           item_d;
  logic [trb_pkg::FILL_W-1:0]  fill_q;
  logic [CW-1:0]               count_q;
  trb_pkg::time_t              mark_q;      // last released device time, or first event into an empty buffer

  // scan bookkeeping
  logic [CW-1:0]               rd_idx_q;    // next entry to read
  logic                        cmp_vld_q;   // read data is valid this cycle
  logic [AW-1:0]               cmp_idx_q;   // entry that the read data belongs to
  trb_pkg::time_t              earliest_q;
  logic                        pos_vld_q;
  logic [AW-1:0]               pos_q;
  trb_pkg::entry_t             min_ent_q;   // copy of the earliest stored entry so far
  logic [AW-1:0]               hit_idx_q;
  trb_pkg::entry_t             hit_ent_q;   // entry with the same device time

  logic                        res_vld_q;
  logic                        res_vld_d;
  trb_pkg::out_item_t          res_q;
  trb_pkg::out_item_t          res_d;

  // memory port signals
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  trb_pkg::entry_t             mem_wdata;
  logic                        mem_re;
  trb_pkg::entry_t             mem_rdata;

  trb_pkg::entry_t             new_ent;
  trb_pkg::entry_t             merged_ent;
  logic [LW-1:0]               limit;
  logic                        has_room;
  logic                        drop;
  logic                        late;

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // incoming event in entry layout
  assign new_ent.dev_time      = item_q.dev_time;
  assign new_ent.request_time  = item_q.request_time;
  assign new_ent.receive_time  = item_q.receive_time;
  assign new_ent.request_known = item_q.request_known;
  assign new_ent.receive_known = item_q.receive_known;

  // unknown local times are carried as zero
  always_comb begin
    item_d              = in_i;
    item_d.request_time = in_i.request_known ? in_i.request_time : '0;
    item_d.receive_time = in_i.receive_known ? in_i.receive_time : '0;
  end

  // fill limit saturates at the buffer depth
  assign limit = (LW'(fill_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(fill_q);
  assign has_room = (LW'(count_q) < limit);

  assign drop = !item_q.device_known || (!item_q.request_known && !item_q.receive_known);
  assign late = (count_q != '0) && (item_q.dev_time <= mark_q);

  // one read per scan cycle while entries remain
  assign mem_re = (state_q == S_SCAN) && (rd_idx_q < count_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[AW-1:0];
    mem_wdata = new_ent;
    case (state_q)
      S_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_q;
        mem_wdata = merged_ent;
      end
      S_DECIDE: begin
        if (has_room) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[AW-1:0];
        end else if (pos_vld_q) begin
          // new event takes the slot of the released one
          mem_we    = 1'b1;
          mem_waddr = pos_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // result of the current step, strobed for one cycle
  always_comb begin
    res_d     = '0;
    res_vld_d = 1'b0;
    case (state_q)
      S_CHECK: begin
        if (drop) begin
          res_d.status = trb_pkg::ST_DROPPED;
          res_vld_d    = 1'b1;
        end else if (late) begin
          res_d.status = trb_pkg::ST_LATE;
          res_vld_d    = 1'b1;
        end
      end
      S_MERGE: begin
        res_d.status = trb_pkg::ST_MERGED;
        res_vld_d    = 1'b1;
      end
      S_DECIDE: begin
        res_vld_d = 1'b1;
        if (has_room) begin
          res_d.status = trb_pkg::ST_STORED;
        end else if (pos_vld_q) begin
          // an older stored event goes out, the new one stays
          res_d.status            = trb_pkg::ST_RELEASED;
          res_d.out_dev_time      = min_ent_q.dev_time;
          res_d.out_request_time  = min_ent_q.request_time;
          res_d.out_request_known = min_ent_q.request_known;
          res_d.out_receive_time  = min_ent_q.receive_time;
          res_d.out_receive_known = min_ent_q.receive_known;
        end else begin
          // the new event is the earliest and passes straight through
          res_d.status            = trb_pkg::ST_RELEASED;
          res_d.out_dev_time      = item_q.dev_time;
          res_d.out_request_time  = item_q.request_time;
          res_d.out_request_known = item_q.request_known;
          res_d.out_receive_time  = item_q.receive_time;
          res_d.out_receive_known = item_q.receive_known;
        end
      end
      default: begin
        res_vld_d = 1'b0;
      end
    endcase
  end

  trb_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  trb_merge u_merge (
    .stored_i   (hit_ent_q),
    .incoming_i (new_ent),
    .merged_o   (merged_ent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      item_q     <= '0;
      fill_q     <= trb_pkg::FILL_RESET;
      count_q    <= '0;
      mark_q     <= '0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      earliest_q <= '0;
      pos_vld_q  <= 1'b0;
      pos_q      <= '0;
      min_ent_q  <= '0;
      hit_idx_q  <= '0;
      hit_ent_q  <= '0;
      res_vld_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      res_vld_q <= res_vld_d;
      if (res_vld_d) begin
        res_q <= res_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        fill_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            item_q  <= item_d;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (drop || late) begin
            state_q <= S_IDLE;
          end else begin
            // first event into an empty buffer sets the mark
            if (count_q == '0) begin
              mark_q <= item_q.dev_time;
            end
            earliest_q <= item_q.dev_time;
            pos_vld_q  <= 1'b0;
            rd_idx_q   <= '0;
            cmp_vld_q  <= 1'b0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld_q <= mem_re;
          cmp_idx_q <= rd_idx_q[AW-1:0];
          if (mem_re) begin
            rd_idx_q <= rd_idx_q + CW'(1);
          end
          if (cmp_vld_q && (mem_rdata.dev_time < earliest_q)) begin
            earliest_q <= mem_rdata.dev_time;
            pos_q      <= cmp_idx_q;
            pos_vld_q  <= 1'b1;
            min_ent_q  <= mem_rdata;
            if (!mem_re) begin
              state_q <= S_DECIDE;
            end
          end else if (cmp_vld_q && (mem_rdata.dev_time == item_q.dev_time)) begin
            // duplicate device time, stop the scan
            hit_idx_q <= cmp_idx_q;
            hit_ent_q <= mem_rdata;
            state_q   <= S_MERGE;
          end else if (!mem_re) begin
            state_q <= S_DECIDE;
          end
        end
        S_MERGE: begin
          state_q <= S_IDLE;
        end
        S_DECIDE: begin
          state_q <= S_IDLE;
          if (has_room) begin
            count_q <= count_q + CW'(1);
          end else if (pos_vld_q) begin
            mark_q <= min_ent_q.dev_time;
          end else begin
            mark_q <= item_q.dev_time;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // entry count stays within the memory
  `ASSERT_STD(a_count_bound, (CW'(DEPTH) >= count_q), "entry count beyond depth")
  // each event answers with a single strobe cycle
  `ASSERT_STD(a_strobe_single, res_vld_q |=> !res_vld_q, "result strobe longer than one cycle")
  // memory is only written once the scan has finished
  `ASSERT_STD(a_write_phase, mem_we |-> (state_q == S_MERGE || state_q == S_DECIDE),
              "memory write outside merge or decide")
  // entries are never removed
  `ASSERT_STD(a_count_mono, 1'b1 |=> (count_q >= $past(count_q)), "entry count decreased")

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam trb_pkg::time_t T_MAX = '1;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 212;

  typedef enum logic {ROW_EVENT, ROW_LIMIT} row_kind_e;

  // one line of the directed table: an event or a fill limit write
  typedef struct {
    row_kind_e                  kind;
    trb_pkg::in_item_t          item;
    logic [trb_pkg::FILL_W-1:0] limit;
    bit                         typed;
    trb_pkg::out_item_t         want;
  } plan_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  trb_pkg::in_item_t          in_i;
  logic                       result_valid_o;
  trb_pkg::out_item_t         result_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [trb_pkg::FILL_W-1:0] cfg_data_i;

  // mirror of the buffer contents, mark and fill limit
  trb_pkg::time_t             held_dev [DEPTH];
  trb_pkg::time_t             held_req [DEPTH];
  trb_pkg::time_t             held_rcv [DEPTH];
  logic                       held_rqk [DEPTH];
  logic                       held_rck [DEPTH];
  int                         held_count = 0;
  trb_pkg::time_t             mark_model = '0;
  logic [trb_pkg::FILL_W-1:0] limit_model = trb_pkg::FILL_RESET;

  // outcomes still owed by the block, oldest first
  trb_pkg::out_item_t         outcome_q [$];
  plan_row_t                  plan [$];
  int                         fault_count = 0;

  // typed expectation handed from the driver to the monitor
  bit                         row_typed = 1'b0;
  trb_pkg::out_item_t         row_want = '0;

  timestamp_reorder_buffer #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_i          (in_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // next event's outcome; updates the mirror the way the block updates its buffer
  function automatic trb_pkg::out_item_t resolve_event(trb_pkg::in_item_t ev);
    trb_pkg::out_item_t res;
    trb_pkg::time_t     rq, rc, earliest;
    int                 slot, lim;
    res = '0;
    rq = ev.request_known ? ev.request_time : '0;
    rc = ev.receive_known ? ev.receive_time : '0;
    // unknown device time or no local time at all
    if (!ev.device_known || (!ev.request_known && !ev.receive_known)) begin
      res.status = trb_pkg::ST_DROPPED;
      return res;
    end
    // first event into an empty buffer sets the mark
    if (held_count == 0) begin
      mark_model = ev.dev_time;
    end else if (ev.dev_time <= mark_model) begin
      res.status = trb_pkg::ST_LATE;
      return res;
    end
    earliest = ev.dev_time;
    slot = -1;
    for (int i = 0; i < held_count; i++) begin
      if (held_dev[i] < earliest) begin
        earliest = held_dev[i];
        slot = i;
      end else if (held_dev[i] == ev.dev_time) begin
        // merge: unknown stored time is overwritten, else latest request, earliest receive
        if (!held_rqk[i]) begin
          held_req[i] = rq;
          held_rqk[i] = ev.request_known;
        end else if (ev.request_known && rq > held_req[i]) begin
          held_req[i] = rq;
        end
        if (!held_rck[i]) begin
          held_rcv[i] = rc;
          held_rck[i] = ev.receive_known;
        end else if (ev.receive_known && rc < held_rcv[i]) begin
          held_rcv[i] = rc;
        end
        res.status = trb_pkg::ST_MERGED;
        return res;
      end
    end
    // limit saturates at the depth; a lowered limit leaves the count alone
    lim = (limit_model > DEPTH) ? DEPTH : int'(limit_model);
    if (held_count < lim) begin
      held_dev[held_count] = ev.dev_time;
      held_req[held_count] = rq;
      held_rcv[held_count] = rc;
      held_rqk[held_count] = ev.request_known;
      held_rck[held_count] = ev.receive_known;
      held_count++;
      res.status = trb_pkg::ST_STORED;
      return res;
    end
    res.status = trb_pkg::ST_RELEASED;
    if (slot < 0) begin
      // the new event is the earliest, it goes straight out
      mark_model = ev.dev_time;
      res.out_dev_time      = ev.dev_time;
      res.out_request_time  = rq;
      res.out_request_known = ev.request_known;
      res.out_receive_time  = rc;
      res.out_receive_known = ev.receive_known;
    end else begin
      // the earliest stored entry goes out, the new event takes its slot
      res.out_dev_time      = held_dev[slot];
      res.out_request_time  = held_req[slot];
      res.out_request_known = held_rqk[slot];
      res.out_receive_time  = held_rcv[slot];
      res.out_receive_known = held_rck[slot];
      mark_model = held_dev[slot];
      held_dev[slot] = ev.dev_time;
      held_req[slot] = rq;
      held_rcv[slot] = rc;
      held_rqk[slot] = ev.request_known;
      held_rck[slot] = ev.receive_known;
    end
    return res;
  endfunction

  function automatic trb_pkg::in_item_t ev(trb_pkg::time_t dt, logic dk, trb_pkg::time_t rq,
                                           logic rqk, trb_pkg::time_t rc, logic rck);
    trb_pkg::in_item_t it;
    it.dev_time      = dt;
    it.device_known  = dk;
    it.request_time  = rq;
    it.request_known = rqk;
    it.receive_time  = rc;
    it.receive_known = rck;
    return it;
  endfunction

  function automatic trb_pkg::out_item_t verdict(trb_pkg::status_e s);
    trb_pkg::out_item_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic trb_pkg::out_item_t released(trb_pkg::time_t dt, trb_pkg::time_t rq,
                                                  logic rqk, trb_pkg::time_t rc, logic rck);
    trb_pkg::out_item_t r;
    r.status            = trb_pkg::ST_RELEASED;
    r.out_dev_time      = dt;
    r.out_request_time  = rq;
    r.out_request_known = rqk;
    r.out_receive_time  = rc;
    r.out_receive_known = rck;
    return r;
  endfunction

  function automatic trb_pkg::time_t rand_time();
    logic [63:0] w;
    int          p;
    p = $urandom_range(0, 9);
    w = {$urandom(), $urandom()};
    if (p == 0) return '0;
    if (p == 1) return T_MAX;
    if (p < 4) return trb_pkg::time_t'($urandom_range(0, 1000));
    return w[trb_pkg::TIME_BITS-1:0];
  endfunction

  // mostly events just past the mark or onto stored times, some late ones and noise
  function automatic trb_pkg::in_item_t fresh_event();
    trb_pkg::in_item_t it;
    int                pick;
    logic [1:0]        kn;
    kn = 2'($urandom_range(1, 3));
    it.request_time  = rand_time();
    it.receive_time  = rand_time();
    it.request_known = kn[0];
    it.receive_known = kn[1];
    it.device_known  = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      it.dev_time = mark_model + trb_pkg::time_t'($urandom_range(1, 48));
    end else if (pick < 70 && held_count > 0) begin
      it.dev_time = held_dev[$urandom_range(0, held_count - 1)];
    end else if (pick < 80) begin
      it.dev_time = (mark_model > 8) ?
                    mark_model - trb_pkg::time_t'($urandom_range(0, 8)) : mark_model;
    end else if (pick < 90) begin
      // unknown device time, everything else random
      it.dev_time      = rand_time();
      it.device_known  = 1'b0;
      it.request_known = 1'($urandom_range(0, 1));
      it.receive_known = 1'($urandom_range(0, 1));
    end else begin
      // no local time known
      it.dev_time      = rand_time();
      it.request_known = 1'b0;
      it.receive_known = 1'b0;
    end
    return it;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit steady);
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 40);
    return $urandom_range(41, 120);
  endfunction

  task automatic plan_event(trb_pkg::in_item_t item, bit typed, trb_pkg::out_item_t want);
    plan_row_t row;
    row = '{ROW_EVENT, item, '0, typed, want};
    plan = {plan, row};
  endtask

  task automatic plan_limit(logic [trb_pkg::FILL_W-1:0] v);
    plan_row_t row;
    row = '{ROW_LIMIT, '0, v, 1'b0, '0};
    plan = {plan, row};
  endtask

  // called at a falling edge; returns at the rising edge that takes the transfer
  task automatic send_event(trb_pkg::in_item_t item, bit typed, trb_pkg::out_item_t want,
                            int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    in_i <= item;
    row_typed = typed;
    row_want = want;
    do @(posedge clk_i); while (busy);
  endtask

  // fill limit write, only once every outcome is in
  task automatic write_limit(logic [trb_pkg::FILL_W-1:0] v);
    @(negedge clk_i);
    start <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_outcome(trb_pkg::out_item_t want, trb_pkg::out_item_t got);
    logic [63:0] w [6];
    logic [63:0] g [6];
    string       nm [6];
    w = '{64'(want.status), 64'(want.out_dev_time), 64'(want.out_request_time),
          64'(want.out_request_known), 64'(want.out_receive_time),
          64'(want.out_receive_known)};
    g = '{64'(got.status), 64'(got.out_dev_time), 64'(got.out_request_time),
          64'(got.out_request_known), 64'(got.out_receive_time),
          64'(got.out_receive_known)};
    nm = '{"status", "dev_time", "request_time", "request_known", "receive_time",
           "receive_known"};
    for (int k = 0; k < 6; k++) begin
      if (w[k] !== g[k]) begin
        fault_count++;
        $display("[%0t] %s: expected %0h, actual %0h", $time, nm[k], w[k], g[k]);
      end
    end
  endtask

  // monitor: results first, since a result never belongs to an event taken on the same edge
  always @(posedge clk_i) begin : monitor
    trb_pkg::out_item_t got;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (outcome_q.size() == 0) begin
          fault_count++;
          $display("[%0t] result with nothing outstanding: %0h", $time, result_o);
        end else begin
          check_outcome(outcome_q.pop_front(), result_o);
        end
      end
      if (start && !busy) begin
        // predictor always runs so the mirror stays in step with typed rows too
        got = resolve_event(in_i);
        if (row_typed) begin
          got = row_want;
        end
        outcome_q = {outcome_q, got};
      end
      if (cfg_valid_i && cfg_ready_o) begin
        limit_model = cfg_data_i;
      end
    end
  end

  initial begin : stimulus
    int phase_limit [PHASES];
    start       = 1'b0;
    in_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // limit of zero on an empty buffer: every event that is not dropped goes straight out
    plan_limit(6'd0);
    plan_event(ev(T_MAX, 1, T_MAX, 1, T_MAX, 1), 1, released(T_MAX, T_MAX, 1, T_MAX, 1));
    // unknown receive time leaves as zero
    plan_event(ev(5, 1, 0, 1, T_MAX, 0), 1, released(5, 0, 1, 0, 0));
    plan_event(ev(T_MAX, 0, T_MAX, 1, T_MAX, 1), 1, verdict(trb_pkg::ST_DROPPED));
    plan_event(ev(T_MAX, 1, T_MAX, 0, T_MAX, 0), 1, verdict(trb_pkg::ST_DROPPED));
    plan_limit(trb_pkg::FILL_RESET);
    // first event sets the mark, then equal and older times are late
    plan_event(ev(1000, 1, T_MAX, 1, 123, 0), 1, verdict(trb_pkg::ST_STORED));
    plan_event(ev(1000, 1, 1, 1, 1, 1), 1, verdict(trb_pkg::ST_LATE));
    plan_event(ev(0, 1, 1, 1, 1, 1), 1, verdict(trb_pkg::ST_LATE));
    plan_event(ev(2000, 1, 9, 0, 500, 1), 1, verdict(trb_pkg::ST_STORED));
    // merges: unknown request replaced, earlier receive kept, later request kept
    plan_event(ev(2000, 1, 5, 1, 77, 1), 1, verdict(trb_pkg::ST_MERGED));
    plan_event(ev(2000, 1, 3, 1, T_MAX, 0), 1, verdict(trb_pkg::ST_MERGED));
    plan_event(ev(2000, 1, T_MAX, 1, 100, 1), 1, verdict(trb_pkg::ST_MERGED));
    // unknown stored receive replaced even by another unknown one
    plan_event(ev(2500, 1, 50, 1, 9, 0), 1, verdict(trb_pkg::ST_STORED));
    plan_event(ev(2500, 1, 60, 1, 0, 0), 1, verdict(trb_pkg::ST_MERGED));
    plan_event(ev(2500, 1, 0, 0, 33, 1), 1, verdict(trb_pkg::ST_MERGED));
    plan_event(ev(T_MAX, 1, 0, 1, 0, 1), 1, verdict(trb_pkg::ST_STORED));
    // limit lowered under the count: buffer counts as full
    plan_limit(6'd0);
    plan_event(ev(3000, 1, 3, 1, 4, 1), 0, '0);
    plan_event(ev(1500, 1, 6, 1, 7, 0), 0, '0);
    plan_event(ev(1500, 1, 1, 1, 1, 1), 1, verdict(trb_pkg::ST_LATE));
    plan_event(ev(2000, 1, 1, 1, 1, 1), 1, verdict(trb_pkg::ST_MERGED));
    // limit above the depth saturates
    plan_limit(6'd63);
    plan_event(ev(1600, 1, 2, 1, 2, 1), 1, verdict(trb_pkg::ST_STORED));
    plan_event(ev(1700, 1, 2, 0, 2, 1), 1, verdict(trb_pkg::ST_STORED));
    plan_limit(6'd1);
    plan_event(ev(1800, 1, T_MAX, 1, 0, 1), 0, '0);

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_LIMIT) begin
        write_limit(plan[r].limit);
      end else begin
        @(negedge clk_i);
        send_event(plan[r].item, plan[r].typed, plan[r].want, pick_gap(0));
      end
    end

    // random phases, each under its own fill limit
    phase_limit = '{32, 1, 63, 0, $urandom_range(1, 31), 20, 2, 32};
    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limit[p][trb_pkg::FILL_W-1:0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        @(negedge clk_i);
        // even phases open with a stretch of back-to-back transfers
        send_event(fresh_event(), 0, '0, pick_gap((p % 2 == 0) && (n < 50)));
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    // room for a stray result after the last one
    repeat (40) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
